@@ rtl/core/ssf_pkg.sv @@
// ssf_pkg: shared types, codes and constants of the system supervisor
// used by every module of the block under rtl/core
package ssf_pkg;

    // adc scale and the calibration limit derived from it
    localparam int unsigned ADC_FULL_SCALE   = 4095;
    localparam logic [15:0] ADC_FULL_SCALE_W = 16'(ADC_FULL_SCALE);
    localparam logic [11:0] CAL_LIMIT        = (ADC_FULL_SCALE > 4095) ? 12'd4095
                                                                       : 12'(ADC_FULL_SCALE);

    // persisted record markers
    localparam logic [31:0] MAGIC_WORD     = 32'hA5A5_5A5A;
    localparam logic [31:0] LAYOUT_VERSION = 32'h0000_0002;
    localparam logic [31:0] INVALID_WORD   = 32'hFFFF_FFFF;

    // mode codes
    localparam logic [2:0] MODE_READ_FLASH = 3'd0;
    localparam logic [2:0] MODE_READ_DIP   = 3'd1;
    localparam logic [2:0] MODE_CHECK      = 3'd2;
    localparam logic [2:0] MODE_RESTORE    = 3'd3;
    localparam logic [2:0] MODE_CONFIG     = 3'd4;
    localparam logic [2:0] MODE_NORMAL     = 3'd5;
    localparam logic [2:0] MODE_FAULT      = 3'd6;

    // fault flag bit positions
    localparam int unsigned FF_FAULT = 0;
    localparam int unsigned FF_CUT   = 1;
    localparam int unsigned FF_ALARM = 2;

    // configuration register indexes
    localparam logic [2:0] CFG_FAN_MIN      = 3'd0;
    localparam logic [2:0] CFG_FAN_MAX      = 3'd1;
    localparam logic [2:0] CFG_BLINK_PERIOD = 3'd2;
    localparam logic [2:0] CFG_RECOVERY     = 3'd3;
    localparam logic [2:0] CFG_STRICT       = 3'd4;

    // configuration reset values
    localparam logic [15:0] RST_FAN_MIN      = 16'd0;
    localparam logic [15:0] RST_FAN_MAX      = 16'd8000;
    localparam logic [15:0] RST_BLINK_PERIOD = 16'd500;
    localparam logic [15:0] RST_RECOVERY     = 16'd10000;

    // percent clamp and divide-by-100 reciprocal, exact for products below 2^23
    localparam logic [6:0]  PCT_MAX       = 7'd100;
    localparam int unsigned PROD_W        = 23;
    localparam logic [23:0] DIV100_MULT   = 24'd10737419;
    localparam int unsigned DIV100_SHIFT  = 30;
    localparam int unsigned QUOT_FULL_W   = PROD_W + 24;

    typedef struct packed {
        logic [3:0]  dip_switches;
        logic        light_on_event;
        logic        light_off_event;
        logic        pot_changed_event;
        logic        calib_save_request;
        logic        store_ok;
        logic [31:0] record_magic;
        logic [31:0] record_version;
        logic [31:0] record_light;
        logic [31:0] record_adc_min;
        logic [31:0] record_adc_max;
        logic [7:0]  pot_percent;
    } in_word_t;

    typedef struct packed {
        logic [2:0]  system_state;
        logic        fault_active;
        logic        power_cut;
        logic        alarm;
        logic        light_state;
        logic [2:0]  role_enables;
        logic [15:0] fan_delay;
        logic        store_request;
        logic        store_calib_valid;
        logic [11:0] store_calib_min;
        logic [11:0] store_calib_max;
        logic [1:0]  update_flags;
    } out_word_t;

    typedef struct packed {
        logic [15:0] fan_min;
        logic [15:0] fan_max;
        logic [15:0] blink_period;
        logic [15:0] recovery;
        logic        strict;
    } cfg_t;

    // input word plus the precomputed percent times span product
    typedef struct packed {
        in_word_t            word;
        logic [PROD_W-1:0]   fan_prod;
    } stage_word_t;

endpackage

@@ rtl/core/system_supervisor_fsm.sv @@
// system_supervisor_fsm: a tick word in the input register is evaluated and its result
// word is loaded into the result register on m_data once that register is empty or being taken
// throughput is one word per cycle while the receiver takes the result words: one tick is
// evaluated in a single pass between the input register and the result register
// reset (aresetn low, synchronous) empties both registers, puts the sequencer in the
// read-flash step and loads the configuration defaults; no clearing pass is needed
module system_supervisor_fsm
    import ssf_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    // tick word in
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_data,
    // result word out
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data,
    // configuration write port
    input  logic      cfg_wr_en,
    input  logic [2:0] cfg_addr,
    input  logic [15:0] cfg_wdata
);

    cfg_t        cfg_reg;
    logic        stage_valid;
    stage_word_t stage_word;
    logic        can_load;
    logic        fire;
    out_word_t   result;

    // configuration registers, writes beyond the list are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.fan_min      <= RST_FAN_MIN;
            cfg_reg.fan_max      <= RST_FAN_MAX;
            cfg_reg.blink_period <= RST_BLINK_PERIOD;
            cfg_reg.recovery     <= RST_RECOVERY;
            cfg_reg.strict       <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_FAN_MIN:      cfg_reg.fan_min      <= cfg_wdata;
                CFG_FAN_MAX:      cfg_reg.fan_max      <= cfg_wdata;
                CFG_BLINK_PERIOD: cfg_reg.blink_period <= cfg_wdata;
                CFG_RECOVERY:     cfg_reg.recovery     <= cfg_wdata;
                CFG_STRICT:       cfg_reg.strict       <= cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    // a tick advances when the input register holds a word and the result slot is free
    assign fire = stage_valid && can_load;

    // input register, also forms the percent times span product for the restore step
    ssf_in_stage u_in (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .cfg         (cfg_reg),
        .take        (fire),
        .stage_valid (stage_valid),
        .stage_word  (stage_word)
    );

    // sequencer state and the single-pass tick logic
    ssf_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .fire       (fire),
        .stage_word (stage_word),
        .cfg        (cfg_reg),
        .result     (result)
    );

    // result register, takes a new result only when empty or while its word is being taken
    ssf_out_reg u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (fire),
        .res_in   (result),
        .can_load (can_load),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

@@ rtl/core/ssf_in_stage.sv @@
// ssf_in_stage: input register of the supervisor, also forms percent times fan span
// depends on ssf_pkg
module ssf_in_stage
    import ssf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_word_t    s_data,
    input  cfg_t        cfg,
    input  logic        take,
    output logic        stage_valid,
    output stage_word_t stage_word
);

    logic        valid_reg;
    stage_word_t word_reg;
    logic [6:0]  pct;
    logic [15:0] span;
    logic [PROD_W-1:0] prod;

    assign s_ready     = !valid_reg || take;
    assign stage_valid = valid_reg;
    assign stage_word  = word_reg;

    always_comb begin
        pct  = (s_data.pot_percent > {1'b0, PCT_MAX}) ? PCT_MAX : s_data.pot_percent[6:0];
        span = (cfg.fan_max > cfg.fan_min) ? (cfg.fan_max - cfg.fan_min) : 16'd0;
        prod = PROD_W'(pct) * PROD_W'(span);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            valid_reg <= 1'b1;
        end else if (take) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            word_reg.word     <= s_data;
            word_reg.fan_prod <= prod;
        end
    end

endmodule

@@ rtl/core/ssf_core.sv @@
// ssf_core: supervisor state registers and the one-tick next-state logic
// depends on ssf_pkg
module ssf_core
    import ssf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        fire,
    input  stage_word_t stage_word,
    input  cfg_t        cfg,
    output out_word_t   result
);

    logic [2:0]  mode_reg,   mode_next;
    logic [15:0] fault_el_reg, fault_el_next;
    logic [15:0] blink_el_reg, blink_el_next;
    logic        phase_reg,  phase_next;
    logic        light_reg,  light_next;
    logic        cal_valid_reg, cal_valid_next;
    logic [11:0] cal_min_reg, cal_min_next;
    logic [11:0] cal_max_reg, cal_max_next;
    logic [15:0] fan_reg,    fan_next;
    logic [2:0]  flags_reg,  flags_next;
    logic [2:0]  role_reg,   role_next;

    in_word_t    w;
    logic        forced;
    logic        lamp_req;
    logic        store_req;
    logic        s_cal_valid;
    logic [11:0] s_cal_min;
    logic [11:0] s_cal_max;
    logic [1:0]  upd;
    logic [15:0] bp;
    logic [15:0] rp;
    logic [15:0] fe_inc;
    logic [15:0] be_inc;
    logic [QUOT_FULL_W-1:0] quot_full;

    always_comb begin
        w         = stage_word.word;
        forced    = w.dip_switches[3];
        bp        = (cfg.blink_period == 16'd0) ? 16'd1 : cfg.blink_period;
        rp        = (cfg.recovery == 16'd0) ? 16'd1 : cfg.recovery;
        fe_inc    = (fault_el_reg == 16'hFFFF) ? fault_el_reg : fault_el_reg + 16'd1;
        be_inc    = (blink_el_reg == 16'hFFFF) ? blink_el_reg : blink_el_reg + 16'd1;
        // divide by 100 through the reciprocal
        quot_full = QUOT_FULL_W'(stage_word.fan_prod) * QUOT_FULL_W'(DIV100_MULT);

        mode_next      = mode_reg;
        fault_el_next  = fault_el_reg;
        blink_el_next  = blink_el_reg;
        phase_next     = phase_reg;
        light_next     = light_reg;
        cal_valid_next = cal_valid_reg;
        cal_min_next   = cal_min_reg;
        cal_max_next   = cal_max_reg;
        fan_next       = fan_reg;
        flags_next     = flags_reg;
        role_next      = role_reg;
        lamp_req       = 1'b0;
        store_req      = 1'b0;
        s_cal_valid    = 1'b0;
        s_cal_min      = 12'd0;
        s_cal_max      = 12'd0;
        upd            = 2'd0;

        case (mode_reg)
            MODE_READ_FLASH: begin
                light_next     = 1'b0;
                cal_valid_next = 1'b0;
                cal_min_next   = 12'd0;
                cal_max_next   = CAL_LIMIT;
                if (w.record_magic == MAGIC_WORD) begin
                    if (w.record_version == LAYOUT_VERSION) begin
                        light_next = w.record_light[0];
                        if (w.record_adc_min != INVALID_WORD
                                && w.record_adc_max != INVALID_WORD
                                && w.record_adc_min <= {20'd0, CAL_LIMIT}
                                && w.record_adc_max <= {20'd0, CAL_LIMIT}
                                && w.record_adc_max > w.record_adc_min) begin
                            cal_valid_next = 1'b1;
                            cal_min_next   = w.record_adc_min[11:0];
                            cal_max_next   = w.record_adc_max[11:0];
                        end
                    end else begin
                        light_next = w.record_version[0];
                    end
                end
                mode_next = MODE_READ_DIP;
            end
            MODE_READ_DIP: begin
                role_next = w.dip_switches[2:0];
                mode_next = MODE_CHECK;
            end
            MODE_CHECK: begin
                mode_next = MODE_RESTORE;
            end
            MODE_RESTORE: begin
                fan_next  = cfg.fan_min + quot_full[DIV100_SHIFT +: 16];
                mode_next = MODE_CONFIG;
            end
            MODE_CONFIG: begin
                role_next  = w.dip_switches[2:0];
                flags_next = 3'd0;
                mode_next  = MODE_NORMAL;
            end
            MODE_NORMAL: begin
                role_next = w.dip_switches[2:0];
                if (forced) begin
                    fault_el_next        = 16'd0;
                    blink_el_next        = 16'd0;
                    phase_next           = 1'b1;
                    flags_next[FF_ALARM] = 1'b1;
                    mode_next            = MODE_FAULT;
                end else begin
                    if (w.light_on_event) begin
                        light_next = 1'b1;
                        lamp_req   = 1'b1;
                    end
                    // off wins over on
                    if (w.light_off_event) begin
                        light_next = 1'b0;
                        lamp_req   = 1'b1;
                    end
                    upd = {w.pot_changed_event, lamp_req};
                    if (lamp_req || w.calib_save_request) begin
                        store_req = 1'b1;
                        if (cal_valid_reg && cal_max_reg > cal_min_reg
                                && {4'd0, cal_max_reg} <= ADC_FULL_SCALE_W) begin
                            s_cal_valid = 1'b1;
                            s_cal_min   = cal_min_reg;
                            s_cal_max   = cal_max_reg;
                        end
                        if (!w.store_ok && cfg.strict && lamp_req) begin
                            fault_el_next        = 16'd0;
                            blink_el_next        = 16'd0;
                            phase_next           = 1'b1;
                            flags_next[FF_ALARM] = 1'b1;
                            mode_next            = MODE_FAULT;
                        end
                    end
                end
            end
            MODE_FAULT: begin
                role_next = w.dip_switches[2:0];
                if (!forced) begin
                    flags_next    = 3'd0;
                    fault_el_next = 16'd0;
                    blink_el_next = 16'd0;
                    phase_next    = 1'b0;
                    mode_next     = MODE_NORMAL;
                end else begin
                    flags_next[FF_FAULT] = 1'b1;
                    flags_next[FF_CUT]   = 1'b1;
                    fault_el_next        = fe_inc;
                    blink_el_next        = be_inc;
                    if (be_inc >= bp) begin
                        blink_el_next        = 16'd0;
                        phase_next           = !phase_reg;
                        flags_next[FF_ALARM] = !phase_reg;
                    end
                    if (fe_inc >= rp) begin
                        fault_el_next = 16'd0;
                        blink_el_next = 16'd0;
                        mode_next     = MODE_READ_FLASH;
                    end
                end
            end
            default: begin
                mode_next = MODE_READ_FLASH;
            end
        endcase

        result.system_state      = mode_next;
        result.fault_active      = flags_next[FF_FAULT];
        result.power_cut         = flags_next[FF_CUT];
        result.alarm             = flags_next[FF_ALARM];
        result.light_state       = light_next;
        result.role_enables      = role_next;
        result.fan_delay         = fan_next;
        result.store_request     = store_req;
        result.store_calib_valid = s_cal_valid;
        result.store_calib_min   = s_cal_min;
        result.store_calib_max   = s_cal_max;
        result.update_flags      = upd;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_READ_FLASH;
            fault_el_reg  <= 16'd0;
            blink_el_reg  <= 16'd0;
            phase_reg     <= 1'b0;
            light_reg     <= 1'b0;
            cal_valid_reg <= 1'b0;
            cal_min_reg   <= 12'd0;
            cal_max_reg   <= 12'd4095;
            fan_reg       <= 16'd0;
            flags_reg     <= 3'd0;
            role_reg      <= 3'd0;
        end else if (fire) begin
            mode_reg      <= mode_next;
            fault_el_reg  <= fault_el_next;
            blink_el_reg  <= blink_el_next;
            phase_reg     <= phase_next;
            light_reg     <= light_next;
            cal_valid_reg <= cal_valid_next;
            cal_min_reg   <= cal_min_next;
            cal_max_reg   <= cal_max_next;
            fan_reg       <= fan_next;
            flags_reg     <= flags_next;
            role_reg      <= role_next;
        end
    end

endmodule

@@ rtl/core/ssf_out_reg.sv @@
// ssf_out_reg: result register of the supervisor, holds a word until it is taken
// depends on ssf_pkg
module ssf_out_reg
    import ssf_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      load,
    input  out_word_t res_in,
    output logic      can_load,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);

    logic      valid_reg;
    out_word_t data_reg;

    assign can_load = !valid_reg || m_ready;
    assign m_valid  = valid_reg;
    assign m_data   = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= res_in;
        end
    end

endmodule

@@ rtl/core/ssf_checker.sv @@
// ssf_checker: port-level assertions for the supervisor, bound to the top level
// depends on ssf_pkg and system_supervisor_fsm
module ssf_checker
    import ssf_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input in_word_t   s_data,
    input logic       m_valid,
    input logic       m_ready,
    input out_word_t  m_data
);

    // a stalled tick word holds
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data))
        else $error("tick word changed while stalled");

    // a stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    // fault and power-cut flags are always set and cleared together
    a_cut_tracks_fault: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.power_cut == m_data.fault_active)
        else $error("power cut differs from fault flag");

    // a calibration payload only rides on a store request and is ordered
    a_calib_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.store_calib_valid |->
            m_data.store_request && m_data.store_calib_max > m_data.store_calib_min)
        else $error("calibration payload without store or out of order");

    // event updates come only from normal mode, possibly ending in strict fault
    a_update_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.update_flags != 2'd0 |->
            m_data.system_state == MODE_NORMAL || m_data.system_state == MODE_FAULT)
        else $error("update flags outside normal mode");

endmodule

bind system_supervisor_fsm ssf_checker u_ssf_checker (.*);

@@ dv/system_supervisor_fsm_tb.sv @@
// system_supervisor_fsm_tb: self-checking testbench of the supervisor state machine
// drives tick words, predicts every result word and compares it field by field
// depends on ssf_pkg and the system_supervisor_fsm rtl only
module system_supervisor_fsm_tb;
    import ssf_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned MAX_SHOWN   = 10;

    // clock, reset and block ports, all driven ones known from time zero
    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    in_word_t    s_data    = '0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    out_word_t   m_data;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_addr  = CFG_FAN_MIN;
    logic [15:0] cfg_wdata = '0;

    // shadow of the supervisor state, own copy kept beside the block
    typedef struct {
        logic [2:0]  mode;
        logic [15:0] fault_cnt;
        logic [15:0] blink_cnt;
        logic        blink_on;
        logic        lamp_on;
        logic        cal_ok;
        logic [11:0] cal_lo;
        logic [11:0] cal_hi;
        logic [15:0] fan;
        logic [2:0]  flags;
        logic [2:0]  roles;
    } supervisor_t;

    supervisor_t sup;
    cfg_t        cfg_now;
    out_word_t   pending_results[$];

    int unsigned cycle_count = 0;
    int unsigned n_results   = 0;
    int unsigned n_errors    = 0;
    int          force_left  = 0;
    // idling switches and the long receiver hold-off request
    bit          tx_idle_en  = 1'b1;
    bit          rx_idle_en  = 1'b1;
    int          hold_cycles = 0;

    system_supervisor_fsm i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // run watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // prediction: advance the shadow state by one tick, return its word
    // ------------------------------------------------------------------
    function automatic void start_fault();
        sup.fault_cnt       = '0;
        sup.blink_cnt       = '0;
        sup.blink_on        = 1'b1;
        sup.flags[FF_ALARM] = 1'b1;
        sup.mode            = MODE_FAULT;
    endfunction

    function automatic out_word_t supervise_tick(input in_word_t w);
        out_word_t   r;
        logic        forced;
        logic        lamp_req;
        int unsigned pct;
        int unsigned span;
        int unsigned bp;
        int unsigned rp;
        r         = '0;
        forced    = w.dip_switches[3];
        lamp_req  = 1'b0;
        case (sup.mode)
            MODE_READ_FLASH: begin
                // defaults first, then whatever the record allows
                sup.lamp_on = 1'b0;
                sup.cal_ok  = 1'b0;
                sup.cal_lo  = '0;
                sup.cal_hi  = CAL_LIMIT;
                if (w.record_magic == MAGIC_WORD) begin
                    if (w.record_version == LAYOUT_VERSION) begin
                        sup.lamp_on = w.record_light[0];
                        if (w.record_adc_min != INVALID_WORD &&
                            w.record_adc_max != INVALID_WORD &&
                            w.record_adc_min <= CAL_LIMIT &&
                            w.record_adc_max <= CAL_LIMIT &&
                            w.record_adc_max > w.record_adc_min) begin
                            sup.cal_ok = 1'b1;
                            sup.cal_lo = w.record_adc_min[11:0];
                            sup.cal_hi = w.record_adc_max[11:0];
                        end
                    end else begin
                        // legacy layout keeps the light in the version word
                        sup.lamp_on = w.record_version[0];
                    end
                end
                sup.mode = MODE_READ_DIP;
            end
            MODE_READ_DIP: begin
                sup.roles = w.dip_switches[2:0];
                sup.mode  = MODE_CHECK;
            end
            MODE_CHECK: begin
                sup.mode = MODE_RESTORE;
            end
            MODE_RESTORE: begin
                pct  = (w.pot_percent > PCT_MAX) ? PCT_MAX : w.pot_percent;
                span = (cfg_now.fan_max > cfg_now.fan_min) ?
                       cfg_now.fan_max - cfg_now.fan_min : 0;
                sup.fan  = 16'(cfg_now.fan_min + (pct * span) / 100);
                sup.mode = MODE_CONFIG;
            end
            MODE_CONFIG: begin
                sup.roles = w.dip_switches[2:0];
                sup.flags = '0;
                sup.mode  = MODE_NORMAL;
            end
            MODE_NORMAL: begin
                sup.roles = w.dip_switches[2:0];
                if (forced) begin
                    start_fault();
                end else begin
                    if (w.light_on_event) begin
                        sup.lamp_on = 1'b1;
                        lamp_req    = 1'b1;
                    end
                    // off wins over on
                    if (w.light_off_event) begin
                        sup.lamp_on = 1'b0;
                        lamp_req    = 1'b1;
                    end
                    r.update_flags = {w.pot_changed_event, lamp_req};
                    if (lamp_req || w.calib_save_request) begin
                        r.store_request = 1'b1;
                        if (sup.cal_ok && sup.cal_hi > sup.cal_lo &&
                            sup.cal_hi <= ADC_FULL_SCALE) begin
                            r.store_calib_valid = 1'b1;
                            r.store_calib_min   = sup.cal_lo;
                            r.store_calib_max   = sup.cal_hi;
                        end
                        if (!w.store_ok && cfg_now.strict && lamp_req)
                            start_fault();
                    end
                end
            end
            MODE_FAULT: begin
                bp = (cfg_now.blink_period == 0) ? 1 : cfg_now.blink_period;
                rp = (cfg_now.recovery == 0) ? 1 : cfg_now.recovery;
                sup.roles = w.dip_switches[2:0];
                if (!forced) begin
                    sup.flags     = '0;
                    sup.fault_cnt = '0;
                    sup.blink_cnt = '0;
                    sup.blink_on  = 1'b0;
                    sup.mode      = MODE_NORMAL;
                end else begin
                    sup.flags[FF_FAULT] = 1'b1;
                    sup.flags[FF_CUT]   = 1'b1;
                    if (sup.fault_cnt != 16'hFFFF) sup.fault_cnt++;
                    if (sup.blink_cnt != 16'hFFFF) sup.blink_cnt++;
                    if (sup.blink_cnt >= bp) begin
                        sup.blink_cnt       = '0;
                        sup.blink_on        = ~sup.blink_on;
                        sup.flags[FF_ALARM] = sup.blink_on;
                    end
                    // timeout: retry init, flags held until the configure step
                    if (sup.fault_cnt >= rp) begin
                        sup.fault_cnt = '0;
                        sup.blink_cnt = '0;
                        sup.mode      = MODE_READ_FLASH;
                    end
                end
            end
            default: begin
                sup.mode = MODE_READ_FLASH;
            end
        endcase
        r.system_state = sup.mode;
        r.fault_active = sup.flags[FF_FAULT];
        r.power_cut    = sup.flags[FF_CUT];
        r.alarm        = sup.flags[FF_ALARM];
        r.light_state  = sup.lamp_on;
        r.role_enables = sup.roles;
        r.fan_delay    = sup.fan;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // result side: random stalls plus an optional long hold-off
    // ------------------------------------------------------------------
    initial begin : result_sink
        int stall;
        forever begin
            @(negedge aclk);
            stall = rx_idle_en ? $urandom_range(0, 5) : 0;
            // long hold-off counted here, sender keeps offering meanwhile
            stall += hold_cycles;
            hold_cycles = 0;
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    task automatic check_field(input string fname, input logic [15:0] want_v,
                               input logic [15:0] got_v);
        if (want_v !== got_v) begin
            n_errors++;
            if (n_errors <= MAX_SHOWN)
                $display("mismatch in %s of result word %0d: expected %0h, got %0h",
                         fname, n_results, want_v, got_v);
        end
    endtask

    // compare each accepted result word with the oldest prediction
    always @(posedge aclk) begin : result_check
        out_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                n_errors++;
                if (n_errors <= MAX_SHOWN)
                    $display("result word %0d arrived with nothing predicted: %h",
                             n_results, m_data);
            end else begin
                want = pending_results.pop_front();
                check_field("system_state", want.system_state, m_data.system_state);
                check_field("fault_active", want.fault_active, m_data.fault_active);
                check_field("power_cut", want.power_cut, m_data.power_cut);
                check_field("alarm", want.alarm, m_data.alarm);
                check_field("light_state", want.light_state, m_data.light_state);
                check_field("role_enables", want.role_enables, m_data.role_enables);
                check_field("fan_delay", want.fan_delay, m_data.fan_delay);
                check_field("store_request", want.store_request, m_data.store_request);
                check_field("store_calib_valid", want.store_calib_valid,
                            m_data.store_calib_valid);
                check_field("store_calib_min", want.store_calib_min,
                            m_data.store_calib_min);
                check_field("store_calib_max", want.store_calib_max,
                            m_data.store_calib_max);
                check_field("update_flags", want.update_flags, m_data.update_flags);
            end
            n_results++;
        end
    end

    // ------------------------------------------------------------------
    // input side helpers
    // ------------------------------------------------------------------
    // offer one tick word, predict its result at the accepting edge
    task automatic send_tick(input in_word_t w);
        int gap;
        gap = tx_idle_en ? $urandom_range(0, 5) : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(supervise_tick(w));
    endtask

    // stop offering and wait until every predicted word has come back
    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        // block is empty once the last word is taken, leave some margin
        repeat (4) @(negedge aclk);
    endtask

    // write all five registers while the block is idle
    task automatic set_config(input cfg_t c);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= CFG_FAN_MIN;
        cfg_wdata <= c.fan_min;
        @(negedge aclk);
        cfg_addr  <= CFG_FAN_MAX;
        cfg_wdata <= c.fan_max;
        @(negedge aclk);
        cfg_addr  <= CFG_BLINK_PERIOD;
        cfg_wdata <= c.blink_period;
        @(negedge aclk);
        cfg_addr  <= CFG_RECOVERY;
        cfg_wdata <= c.recovery;
        @(negedge aclk);
        cfg_addr  <= CFG_STRICT;
        cfg_wdata <= {15'd0, c.strict};
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        cfg_now = c;
    endtask

    // tick word with no events, successful store and random don't-care words
    function automatic in_word_t quiet_tick(input logic [3:0] dip);
        in_word_t w;
        w                    = '0;
        w.dip_switches       = dip;
        w.store_ok           = 1'b1;
        w.record_magic       = $urandom;
        w.record_version     = $urandom;
        w.record_light       = $urandom;
        w.record_adc_min     = $urandom;
        w.record_adc_max     = $urandom;
        w.pot_percent        = 8'($urandom_range(0, 255));
        return w;
    endfunction

    // the five init ticks: record on the first, pot percent on the restore step
    task automatic run_init(input logic [31:0] magic, input logic [31:0] version,
                            input logic [31:0] light, input logic [31:0] lo,
                            input logic [31:0] hi, input logic [7:0] pct);
        in_word_t w;
        for (int i = 0; i < 5; i++) begin
            w = quiet_tick(4'($urandom_range(0, 7)));
            if (i == 0) begin
                w.record_magic   = magic;
                w.record_version = version;
                w.record_light   = light;
                w.record_adc_min = lo;
                w.record_adc_max = hi;
            end
            if (i == 3) w.pot_percent = pct;
            send_tick(w);
        end
    endtask

    // calibration word: mostly in range, sometimes invalid or too large
    function automatic logic [31:0] record_cal_word();
        case ($urandom_range(0, 9))
            0:       return INVALID_WORD;
            1:       return $urandom;
            2:       return 32'($urandom_range(4096, 70000));
            default: return 32'($urandom_range(0, 4095));
        endcase
    endfunction

    // random tick: normal operation with bursts of forced fault
    function automatic in_word_t random_tick();
        in_word_t w;
        w = quiet_tick(4'($urandom_range(0, 7)));
        if (force_left == 0 && $urandom_range(0, 99) < 6)
            force_left = $urandom_range(1, 30);
        if (force_left > 0) begin
            w.dip_switches[3] = 1'b1;
            force_left--;
        end
        w.light_on_event     = ($urandom_range(0, 99) < 30);
        w.light_off_event    = ($urandom_range(0, 99) < 20);
        w.pot_changed_event  = ($urandom_range(0, 99) < 30);
        w.calib_save_request = ($urandom_range(0, 99) < 15);
        w.store_ok           = ($urandom_range(0, 99) < 85);
        if ($urandom_range(0, 9) < 8) w.record_magic = MAGIC_WORD;
        if ($urandom_range(0, 9) < 7) w.record_version = LAYOUT_VERSION;
        w.record_adc_min = record_cal_word();
        w.record_adc_max = record_cal_word();
        if ($urandom_range(0, 9) < 7) w.pot_percent = 8'($urandom_range(0, 100));
        return w;
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    // record read with version 2, full calibration range and clamped pot,
    // zero fan span because max is below min
    task automatic test_init_record();
        run_init(MAGIC_WORD, LAYOUT_VERSION, 32'h1, 32'd0, 32'd4095, 8'd255);
    endtask

    // light on and off together (off wins), pot update, calibration-only save
    task automatic test_normal_events();
        in_word_t w;
        w = quiet_tick(4'b0111);
        w.light_on_event    = 1'b1;
        w.light_off_event   = 1'b1;
        w.pot_changed_event = 1'b1;
        send_tick(w);
        w = quiet_tick(4'b0000);
        w.calib_save_request = 1'b1;
        w.store_ok           = 1'b0;
        send_tick(w);
    endtask

    // failed light save in strict mode, then one fault tick that blinks and
    // times out, then a retry reading a legacy record
    task automatic test_strict_fault();
        in_word_t w;
        w = quiet_tick(4'b0101);
        w.light_on_event = 1'b1;
        w.store_ok       = 1'b0;
        send_tick(w);
        send_tick(quiet_tick(4'b1000));
        run_init(MAGIC_WORD, INVALID_WORD, 32'h0, INVALID_WORD, 32'd0, 8'd0);
    endtask

    // forced fault left at once when the switch clears
    task automatic test_fault_exit();
        send_tick(quiet_tick(4'b1111));
        send_tick(quiet_tick(4'b0010));
    endtask

    // zero periods behave as one, wrong magic loads the defaults
    task automatic test_zero_periods();
        in_word_t w;
        drain_results();
        set_config('{fan_min: 16'd0, fan_max: 16'hFFFF, blink_period: 16'd0,
                     recovery: 16'd0, strict: 1'b0});
        send_tick(quiet_tick(4'b1000));
        send_tick(quiet_tick(4'b1001));
        run_init(32'h0, LAYOUT_VERSION, 32'h1, 32'd1, 32'd2, 8'd100);
        // failed light save without strict mode stays in normal
        w = quiet_tick(4'b0100);
        w.light_on_event = 1'b1;
        w.store_ok       = 1'b0;
        send_tick(w);
    endtask

    // receiver holds off long enough that the block stalls its input,
    // then the sender pauses until everything is back
    task automatic test_backpressure();
        tx_idle_en  = 1'b0;
        hold_cycles = 60;
        for (int i = 0; i < 20; i++) send_tick(random_tick());
        drain_results();
        tx_idle_en = 1'b1;
        for (int i = 0; i < 10; i++) send_tick(random_tick());
    endtask

    // random ticks over several register settings, extremes among them
    task automatic test_random();
        cfg_t c;
        int   lo;
        for (int ph = 0; ph < 4; ph++) begin
            drain_results();
            case (ph)
                0: begin
                    lo = $urandom_range(0, 30000);
                    c  = '{fan_min: 16'(lo), fan_max: 16'(lo + $urandom_range(0, 35535)),
                           blink_period: 16'($urandom_range(1, 4)),
                           recovery: 16'($urandom_range(4, 24)), strict: 1'b1};
                end
                1: c = '{fan_min: 16'd0, fan_max: 16'hFFFF, blink_period: 16'hFFFF,
                         recovery: 16'hFFFF, strict: 1'b0};
                2: c = '{fan_min: RST_FAN_MIN, fan_max: RST_FAN_MAX, blink_period: 16'd2,
                         recovery: 16'd12, strict: 1'($urandom_range(0, 1))};
                default: c = '{fan_min: 16'd1000, fan_max: 16'd500, blink_period: 16'd3,
                               recovery: 16'd40, strict: 1'b1};
            endcase
            set_config(c);
            force_left = 0;
            for (int i = 0; i < 165; i++) begin
                // stretches with and without idling on either side
                if (i % 40 == 0) begin
                    tx_idle_en = ($urandom_range(0, 3) != 0);
                    rx_idle_en = ($urandom_range(0, 3) != 0);
                end
                send_tick(random_tick());
            end
        end
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        // shadow state and registers as after reset
        cfg_now = '{fan_min: RST_FAN_MIN, fan_max: RST_FAN_MAX,
                    blink_period: RST_BLINK_PERIOD, recovery: RST_RECOVERY, strict: 1'b0};
        sup = '{mode: MODE_READ_FLASH, fault_cnt: '0, blink_cnt: '0, blink_on: 1'b0,
                lamp_on: 1'b0, cal_ok: 1'b0, cal_lo: '0, cal_hi: 12'd4095,
                fan: '0, flags: '0, roles: '0};
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(negedge aclk);

        // directed part: extremes with strict mode and an inverted fan range
        set_config('{fan_min: 16'hFFFF, fan_max: 16'd0, blink_period: 16'd1,
                     recovery: 16'd1, strict: 1'b1});
        test_init_record();
        test_normal_events();
        test_strict_fault();
        test_fault_exit();
        test_zero_periods();
        test_backpressure();
        test_random();

        drain_results();
        repeat (10) @(posedge aclk);
        n_errors += pending_results.size();
        if (n_errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
